// ===== src/ftsm_pkg.sv =====
package ftsm_pkg;

    // Field widths
    localparam int unsigned INTERVAL_BITS = 24;
    localparam int unsigned FRAC_BITS     = 8;
    localparam int unsigned BASE_BITS     = INTERVAL_BITS + FRAC_BITS;
    localparam int unsigned CLOCK_BITS    = 48;
    localparam int unsigned SPAN_BITS     = 32;
    localparam int unsigned COUNT_BITS    = 24;
    localparam int unsigned SUM_BITS      = 40;
    localparam int unsigned LOST_BITS     = 48;
    localparam int unsigned GAIN_BITS     = 16;
    localparam int unsigned FACTOR_BITS   = 8;
    localparam int unsigned PERIOD_BITS   = 32;
    localparam int unsigned CFG_DATA_BITS = 32;
    localparam int unsigned CFG_IDX_BITS  = 3;

    // Register reset values
    localparam logic [FACTOR_BITS-1:0]   FACTOR_RESET = 8'd20;
    localparam logic [INTERVAL_BITS-1:0] MARGIN_RESET = 24'd4000;
    localparam logic [INTERVAL_BITS-1:0] IGNORE_RESET = 24'd1000000;
    localparam logic [GAIN_BITS-1:0]     GAIN_RESET   = 16'd1311;
    localparam logic [PERIOD_BITS-1:0]   PERIOD_RESET = 32'd10000000;

    // Register indexes on the config port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SPIKE_FACTOR   = 3'd0,
        REG_SPIKE_MARGIN   = 3'd1,
        REG_IGNORE_ABOVE   = 3'd2,
        REG_BASELINE_GAIN  = 3'd3,
        REG_SUMMARY_PERIOD = 3'd4
    } cfg_index_t;

    // Result classes; the front marks countable intervals CLS_NORMAL and
    // the back refines them into primed, normal or spike.
    typedef enum logic [2:0] {
        CLS_UNFOCUSED = 3'd0,
        CLS_REARM     = 3'd1,
        CLS_RANGE     = 3'd2,
        CLS_PRIMED    = 3'd3,
        CLS_NORMAL    = 3'd4,
        CLS_SPIKE     = 3'd5
    } frame_class_t;

    typedef struct packed {
        logic [FACTOR_BITS-1:0]   spike_factor_eighths;
        logic [INTERVAL_BITS-1:0] spike_margin_us;
        logic [INTERVAL_BITS-1:0] ignore_above_us;
        logic [GAIN_BITS-1:0]     baseline_gain;
        logic [PERIOD_BITS-1:0]   summary_period_us;
    } cfg_t;

    // Classified item between front and back
    typedef struct packed {
        frame_class_t             kind;
        logic [INTERVAL_BITS-1:0] frame_time_us;
    } entry_t;

    typedef struct packed {
        frame_class_t             frame_class;
        logic [BASE_BITS-1:0]     baseline_level;
        logic                     summary_valid;
        logic [SPAN_BITS-1:0]     window_span_us;
        logic [COUNT_BITS-1:0]    window_frames;
        logic [SUM_BITS-1:0]      window_sum_us;
        logic [INTERVAL_BITS-1:0] window_max_us;
        logic [COUNT_BITS-1:0]    window_spikes;
        logic [LOST_BITS-1:0]     window_lost;
    } result_t;

endpackage

// ===== src/frame_time_spike_monitor.sv =====
// Frame time spike monitor.
// Input channel: drive frame_time_us and has_focus with push; a transaction
// completes on a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result sits on the result
// ports; it is taken on an edge where pop is high. Every input transaction
// yields exactly one result, in order.
// Config: cfg_write with cfg_index/cfg_data writes one register; write only
// while no transaction is in flight.
// Path: the front classifier writes a two-entry queue, and the back unit
// takes from it and writes a two-entry result queue.
// Throughput: one transaction per cycle while pop keeps the result queue
// from filling, set by the back unit's combinational spike test and
// baseline update (one 32x8 and one 32x16 multiply).
// Reset: registers return to their defaults, the baseline is unprimed, focus
// is assumed present, window counters and both queues are cleared.
// Stalls: if pop stays low the result queue fills, the back unit stops, the
// middle queue fills and full rises; nothing is lost or duplicated.
module frame_time_spike_monitor (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [ftsm_pkg::INTERVAL_BITS-1:0]    frame_time_us,
    input  logic                                  has_focus,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [2:0]                            frame_class,
    output logic [ftsm_pkg::BASE_BITS-1:0]        baseline_level,
    output logic                                  summary_valid,
    output logic [ftsm_pkg::SPAN_BITS-1:0]        window_span_us,
    output logic [ftsm_pkg::COUNT_BITS-1:0]       window_frames,
    output logic [ftsm_pkg::SUM_BITS-1:0]         window_sum_us,
    output logic [ftsm_pkg::INTERVAL_BITS-1:0]    window_max_us,
    output logic [ftsm_pkg::COUNT_BITS-1:0]       window_spikes,
    output logic [ftsm_pkg::LOST_BITS-1:0]        window_lost,
    input  logic                                  cfg_write,
    input  logic [ftsm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [ftsm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int unsigned ENTRY_BITS  = $bits(ftsm_pkg::entry_t);
    localparam int unsigned RESULT_BITS = $bits(ftsm_pkg::result_t);

    ftsm_pkg::cfg_t    cfg_reg;
    ftsm_pkg::entry_t  front_data;
    ftsm_pkg::entry_t  mid_data;
    ftsm_pkg::result_t back_data;
    ftsm_pkg::result_t out_word;
    logic              front_write;
    logic              mid_full;
    logic              mid_empty;
    logic              mid_pop;
    logic              res_full;
    logic              back_write;
    logic [ENTRY_BITS-1:0]  mid_rd_bits;
    logic [RESULT_BITS-1:0] res_rd_bits;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spike_factor_eighths <= ftsm_pkg::FACTOR_RESET;
            cfg_reg.spike_margin_us      <= ftsm_pkg::MARGIN_RESET;
            cfg_reg.ignore_above_us      <= ftsm_pkg::IGNORE_RESET;
            cfg_reg.baseline_gain        <= ftsm_pkg::GAIN_RESET;
            cfg_reg.summary_period_us    <= ftsm_pkg::PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ftsm_pkg::REG_SPIKE_FACTOR:
                    cfg_reg.spike_factor_eighths <= cfg_data[ftsm_pkg::FACTOR_BITS-1:0];
                ftsm_pkg::REG_SPIKE_MARGIN:
                    cfg_reg.spike_margin_us <= cfg_data[ftsm_pkg::INTERVAL_BITS-1:0];
                ftsm_pkg::REG_IGNORE_ABOVE:
                    cfg_reg.ignore_above_us <= cfg_data[ftsm_pkg::INTERVAL_BITS-1:0];
                ftsm_pkg::REG_BASELINE_GAIN:
                    cfg_reg.baseline_gain <= cfg_data[ftsm_pkg::GAIN_BITS-1:0];
                ftsm_pkg::REG_SUMMARY_PERIOD:
                    cfg_reg.summary_period_us <= cfg_data[ftsm_pkg::PERIOD_BITS-1:0];
                default:
                begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    // Front: focus tracking and range classification
    ftsm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .frame_time_us   (frame_time_us),
        .has_focus       (has_focus),
        .ignore_above_us (cfg_reg.ignore_above_us),
        .q_full          (mid_full),
        .q_write         (front_write),
        .q_data          (front_data)
    );

    assign full = mid_full;

    // Queue between front and back
    ftsm_fifo #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (2)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_write),
        .wr_data (front_data),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_rd_bits),
        .empty   (mid_empty)
    );

    assign mid_data = ftsm_pkg::entry_t'(mid_rd_bits);

    // Back: baseline, spike test and window statistics
    ftsm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_empty  (mid_empty),
        .in_data   (mid_data),
        .in_pop    (mid_pop),
        .out_full  (res_full),
        .out_write (back_write),
        .out_data  (back_data)
    );

    // Result queue
    ftsm_fifo #(
        .WIDTH (RESULT_BITS),
        .DEPTH (2)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (back_write),
        .wr_data (back_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_bits),
        .empty   (empty)
    );

    // Result ports
    assign out_word       = ftsm_pkg::result_t'(res_rd_bits);
    assign frame_class    = out_word.frame_class;
    assign baseline_level = out_word.baseline_level;
    assign summary_valid  = out_word.summary_valid;
    assign window_span_us = out_word.window_span_us;
    assign window_frames  = out_word.window_frames;
    assign window_sum_us  = out_word.window_sum_us;
    assign window_max_us  = out_word.window_max_us;
    assign window_spikes  = out_word.window_spikes;
    assign window_lost    = out_word.window_lost;

endmodule

// ===== src/ftsm_fifo.sv =====
module ftsm_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0]     mem_reg [DEPTH];
    logic [ADDR_BITS-1:0] wr_ptr_reg;
    logic [ADDR_BITS-1:0] rd_ptr_reg;
    logic [ADDR_BITS:0]   count_reg;
    logic [ADDR_BITS:0]   count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full    = (count_reg == (ADDR_BITS + 1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == ADDR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == ADDR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/ftsm_front.sv =====
module ftsm_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [ftsm_pkg::INTERVAL_BITS-1:0]   frame_time_us,
    input  logic                                 has_focus,
    input  logic [ftsm_pkg::INTERVAL_BITS-1:0]   ignore_above_us,
    input  logic                                 q_full,
    output logic                                 q_write,
    output ftsm_pkg::entry_t                     q_data
);

    logic had_focus_reg;
    logic had_focus_next;

    assign q_write = push && !q_full;

    // Focus tracking and range check
    always_comb
    begin
        had_focus_next       = had_focus_reg;
        q_data.frame_time_us = frame_time_us;
        if (!has_focus)
        begin
            had_focus_next = 1'b0;
            q_data.kind    = ftsm_pkg::CLS_UNFOCUSED;
        end
        else if (!had_focus_reg)
        begin
            had_focus_next = 1'b1;
            q_data.kind    = ftsm_pkg::CLS_REARM;
        end
        else if (frame_time_us == '0 || frame_time_us > ignore_above_us)
        begin
            q_data.kind = ftsm_pkg::CLS_RANGE;
        end
        else
        begin
            q_data.kind = ftsm_pkg::CLS_NORMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            had_focus_reg <= 1'b1;
        end
        else if (q_write)
        begin
            had_focus_reg <= had_focus_next;
        end
    end

endmodule

// ===== src/ftsm_back.sv =====
module ftsm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ftsm_pkg::cfg_t       cfg,
    input  logic                 in_empty,
    input  ftsm_pkg::entry_t     in_data,
    output logic                 in_pop,
    input  logic                 out_full,
    output logic                 out_write,
    output ftsm_pkg::result_t    out_data
);

    localparam int unsigned IB = ftsm_pkg::INTERVAL_BITS;
    localparam int unsigned FB = ftsm_pkg::FRAC_BITS;
    localparam int unsigned BB = ftsm_pkg::BASE_BITS;
    localparam int unsigned CB = ftsm_pkg::CLOCK_BITS;
    localparam int unsigned NB = ftsm_pkg::COUNT_BITS;
    localparam int unsigned SB = ftsm_pkg::SUM_BITS;
    localparam int unsigned LB = ftsm_pkg::LOST_BITS;
    localparam int unsigned GB = ftsm_pkg::GAIN_BITS;
    localparam int unsigned RB = BB + ftsm_pkg::FACTOR_BITS;
    localparam int unsigned PB = BB + GB;

    logic [BB-1:0] baseline_reg, baseline_next;
    logic          primed_reg, primed_next;
    logic [CB-1:0] elapsed_reg, elapsed_next;
    logic [CB-1:0] start_reg, start_next;
    logic [NB-1:0] frames_reg, frames_next;
    logic [SB-1:0] sum_reg, sum_next;
    logic [IB-1:0] max_reg, max_next;
    logic [NB-1:0] spikes_reg, spikes_next;
    logic [LB-1:0] lost_reg, lost_next;

    logic          fire;
    logic [IB-1:0] dt;
    logic [BB-1:0] q;
    logic [CB-1:0] elapsed_inc;
    logic [RB-1:0] ratio_prod;
    logic [BB:0]   margin_thr;
    logic          spike;
    logic          move_up;
    logic [BB-1:0] diff;
    logic [PB-1:0] gain_prod;
    logic [PB-1:0] gain_prod_rnd;
    logic [BB-1:0] baseline_upd;
    logic [NB-1:0] frames_inc;
    logic [SB:0]   sum_add;
    logic [SB-1:0] sum_inc;
    logic [IB-1:0] max_upd;
    logic [NB-1:0] spikes_inc;
    logic [LB:0]   lost_add;
    logic [LB-1:0] lost_inc;
    logic [CB-1:0] span;
    logic          emit;

    assign fire      = !in_empty && !out_full;
    assign in_pop    = fire;
    assign out_write = fire;
    assign dt        = in_data.frame_time_us;
    assign q         = {dt, FB'(0)};

    // Spike test: factor/8 ratio and absolute margin
    assign ratio_prod = RB'(baseline_reg) * RB'(cfg.spike_factor_eighths);
    assign margin_thr = (BB + 1)'(baseline_reg) + (BB + 1)'({cfg.spike_margin_us, FB'(0)});
    assign spike      = (RB'({q, 3'b000}) > ratio_prod) && ((BB + 1)'(q) > margin_thr);

    // Baseline step toward q, floor rounding in both directions
    assign move_up       = (q >= baseline_reg);
    assign diff          = move_up ? (q - baseline_reg) : (baseline_reg - q);
    assign gain_prod     = PB'(diff) * PB'(cfg.baseline_gain);
    assign gain_prod_rnd = gain_prod + PB'({GB{1'b1}});
    assign baseline_upd  = move_up ? (baseline_reg + gain_prod[PB-1:GB])
                                   : (baseline_reg - gain_prod_rnd[PB-1:GB]);

    // Saturating window counters
    assign frames_inc = (&frames_reg) ? frames_reg : frames_reg + 1'b1;
    assign spikes_inc = (&spikes_reg) ? spikes_reg : spikes_reg + 1'b1;
    assign sum_add    = (SB + 1)'(sum_reg) + (SB + 1)'(dt);
    assign sum_inc    = sum_add[SB] ? {SB{1'b1}} : sum_add[SB-1:0];
    assign lost_add   = (LB + 1)'(lost_reg) + (LB + 1)'(q - baseline_reg);
    assign lost_inc   = lost_add[LB] ? {LB{1'b1}} : lost_add[LB-1:0];
    assign max_upd    = (dt > max_reg) ? dt : max_reg;

    // Window timing
    assign elapsed_inc = elapsed_reg + CB'(dt);
    assign span        = elapsed_inc - start_reg;
    assign emit        = (span >= CB'(cfg.summary_period_us));

    always_comb
    begin
        baseline_next = baseline_reg;
        primed_next   = primed_reg;
        elapsed_next  = elapsed_reg;
        start_next    = start_reg;
        frames_next   = frames_reg;
        sum_next      = sum_reg;
        max_next      = max_reg;
        spikes_next   = spikes_reg;
        lost_next     = lost_reg;
        out_data      = '0;
        out_data.frame_class = in_data.kind;

        case (in_data.kind)
            ftsm_pkg::CLS_REARM:
            begin
                baseline_next = '0;
                primed_next   = 1'b0;
            end
            ftsm_pkg::CLS_NORMAL:
            begin
                elapsed_next = elapsed_inc;
                if (!primed_reg)
                begin
                    primed_next          = 1'b1;
                    baseline_next        = q;
                    start_next           = elapsed_inc;
                    out_data.frame_class = ftsm_pkg::CLS_PRIMED;
                end
                else
                begin
                    if (spike)
                    begin
                        spikes_next          = spikes_inc;
                        lost_next            = lost_inc;
                        out_data.frame_class = ftsm_pkg::CLS_SPIKE;
                    end
                    else
                    begin
                        baseline_next = baseline_upd;
                    end
                    frames_next = frames_inc;
                    sum_next    = sum_inc;
                    max_next    = max_upd;
                    if (emit)
                    begin
                        out_data.summary_valid  = 1'b1;
                        out_data.window_span_us = (|span[CB-1:ftsm_pkg::SPAN_BITS])
                                                  ? {ftsm_pkg::SPAN_BITS{1'b1}}
                                                  : span[ftsm_pkg::SPAN_BITS-1:0];
                        out_data.window_frames  = frames_next;
                        out_data.window_sum_us  = sum_next;
                        out_data.window_max_us  = max_next;
                        out_data.window_spikes  = spikes_next;
                        out_data.window_lost    = lost_next;
                        start_next  = elapsed_inc;
                        frames_next = '0;
                        sum_next    = '0;
                        max_next    = '0;
                        spikes_next = '0;
                        lost_next   = '0;
                    end
                end
            end
            default:
            begin
                // unfocused or out of range: state untouched
            end
        endcase

        out_data.baseline_level = baseline_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= '0;
            primed_reg   <= 1'b0;
            elapsed_reg  <= '0;
            start_reg    <= '0;
            frames_reg   <= '0;
            sum_reg      <= '0;
            max_reg      <= '0;
            spikes_reg   <= '0;
            lost_reg     <= '0;
        end
        else if (fire)
        begin
            baseline_reg <= baseline_next;
            primed_reg   <= primed_next;
            elapsed_reg  <= elapsed_next;
            start_reg    <= start_next;
            frames_reg   <= frames_next;
            sum_reg      <= sum_next;
            max_reg      <= max_next;
            spikes_reg   <= spikes_next;
            lost_reg     <= lost_next;
        end
    end

endmodule
